// ===== sv/assert_macros.svh =====
// Shared assertion macros: clocked on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/genv_pkg.sv =====
package genv_pkg;

  localparam int unsigned LEVEL_W = 11;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned START_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 11'h7ff;
  localparam logic [LEVEL_W-1:0] LINEAR_STEP = 11'h020;
  localparam logic [LEVEL_W-1:0] BEND_POINT  = 11'h600;
  localparam logic [LEVEL_W-1:0] BENT_STEP   = 11'h008;

  typedef enum logic [2:0] {
    MODE_LIN_DOWN = 3'd4,
    MODE_EXP_DOWN = 3'd5,
    MODE_LIN_UP   = 3'd6,
    MODE_BENT_UP  = 3'd7
  } env_mode_t;

  // Tick period per rate index; index 0 is the "frozen" rate.
  function automatic logic [CNT_W:0] rate_period(input logic [4:0] rate);
    logic [CNT_W:0] p;
    unique case (rate)
      5'd0:  p = 16'h7800;
      5'd1:  p = 16'd2048;
      5'd2:  p = 16'd1536;
      5'd3:  p = 16'd1280;
      5'd4:  p = 16'd1024;
      5'd5:  p = 16'd768;
      5'd6:  p = 16'd640;
      5'd7:  p = 16'd512;
      5'd8:  p = 16'd384;
      5'd9:  p = 16'd320;
      5'd10: p = 16'd256;
      5'd11: p = 16'd192;
      5'd12: p = 16'd160;
      5'd13: p = 16'd128;
      5'd14: p = 16'd96;
      5'd15: p = 16'd80;
      5'd16: p = 16'd64;
      5'd17: p = 16'd48;
      5'd18: p = 16'd40;
      5'd19: p = 16'd32;
      5'd20: p = 16'd24;
      5'd21: p = 16'd20;
      5'd22: p = 16'd16;
      5'd23: p = 16'd12;
      5'd24: p = 16'd10;
      5'd25: p = 16'd8;
      5'd26: p = 16'd6;
      5'd27: p = 16'd5;
      5'd28: p = 16'd4;
      5'd29: p = 16'd3;
      5'd30: p = 16'd2;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

  // One envelope step for an envelope mode (top mode bit set).
  function automatic logic [LEVEL_W-1:0] step_level(input logic [2:0] mode,
                                                    input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] dec;
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W-1:0] res;
    dec = lv - 11'd1;
    sum = {1'b0, lv} + {1'b0, ((mode == MODE_BENT_UP && lv > BEND_POINT) ?
                                BENT_STEP : LINEAR_STEP)};
    unique case (mode)
      MODE_LIN_DOWN: res = (lv > LINEAR_STEP) ? (lv - LINEAR_STEP) : '0;
      MODE_EXP_DOWN: res = (lv != '0) ? (dec - (dec >> 8)) : '0;
      default:       res = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
    endcase
    return res;
  endfunction

endpackage

// ===== sv/gain_envelope_stepper.sv =====
// Gain envelope stepper for one voice.
// cfg_wr_en/cfg_wr_data write the gain byte (mode in bits 7..5, rate in 4..0);
// write it only while no request is in flight.
// Input channel: in_valid/in_stall with in_restart and in_start_level. A
// restart loads the clamped start level and clears the tick counter; any
// other request is one sample tick.
// Output channel: out_valid/out_stall with out_level and out_at_limit, one
// result per input request, in order.
// An accepted request is held in the input register, and its result goes to the
// result register when it advances. Throughput is one request per cycle while
// out_stall is low: the level/counter update is a single pass of logic between
// the input register and the result register.
// When out_stall holds a result, the input register keeps its request and
// in_stall rises, so at most two requests are held inside.
// Reset (rst_n low, synchronous) clears the gain byte, level, tick counter
// and both valid flags.
`include "assert_macros.svh"

module gain_envelope_stepper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [genv_pkg::GAIN_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  input  logic signed [genv_pkg::START_W-1:0] in_start_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [genv_pkg::LEVEL_W-1:0]      out_level,
  output logic                              out_at_limit
);

  logic [genv_pkg::GAIN_W-1:0]  gain_r;
  logic [genv_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [genv_pkg::CNT_W-1:0]   tick_cnt_r, tick_cnt_nxt;

  logic                          s1_valid_r;
  logic                          s1_restart_r;
  logic [genv_pkg::START_W-1:0]  s1_start_r;

  logic                          out_valid_r;
  logic [genv_pkg::LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic                          out_lim_r, out_lim_nxt;

  logic                          out_free, s1_adv, in_acc;
  logic [2:0]                    mode;
  logic [4:0]                    rate;
  logic [genv_pkg::CNT_W:0]      cnt_inc;
  logic [genv_pkg::LEVEL_W-1:0]  start_clamped;
  logic                          at_end, lim_new;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign mode = gain_r[7:5];
  assign rate = gain_r[4:0];

  always_comb begin
    if (s1_start_r[genv_pkg::START_W-1]) begin
      start_clamped = '0;
    end else if (s1_start_r > {5'd0, genv_pkg::LEVEL_MAX}) begin
      start_clamped = genv_pkg::LEVEL_MAX;
    end else begin
      start_clamped = s1_start_r[genv_pkg::LEVEL_W-1:0];
    end
  end

  // downward modes end at 0, upward modes at full scale
  assign at_end  = mode[1] ? (level_r == genv_pkg::LEVEL_MAX) : (level_r == '0);
  assign cnt_inc = {1'b0, tick_cnt_r} + 16'd1;

  always_comb begin
    level_nxt    = level_r;
    tick_cnt_nxt = tick_cnt_r;
    if (s1_restart_r) begin
      level_nxt    = start_clamped;
      tick_cnt_nxt = '0;
    end else if (mode[2] && rate != '0) begin
      if (cnt_inc >= genv_pkg::rate_period(rate)) begin
        tick_cnt_nxt = '0;
        if (!at_end) begin
          level_nxt = genv_pkg::step_level(mode, level_r);
        end
      end else begin
        tick_cnt_nxt = cnt_inc[genv_pkg::CNT_W-1:0];
      end
    end
  end

  assign lim_new = mode[1] ? (level_nxt == genv_pkg::LEVEL_MAX) : (level_nxt == '0);

  always_comb begin
    if (mode[2]) begin
      out_level_nxt = level_nxt;
      out_lim_nxt   = lim_new;
    end else begin
      // direct mode: gain * 16, truncated to the level width
      out_level_nxt = {gain_r[6:0], 4'b0000};
      out_lim_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= '0;
      level_r     <= '0;
      tick_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (s1_adv) begin
        level_r    <= level_nxt;
        tick_cnt_r <= tick_cnt_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_restart_r <= in_restart;
      s1_start_r   <= in_start_level;
    end
    if (s1_adv) begin
      out_level_r <= out_level_nxt;
      out_lim_r   <= out_lim_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_at_limit = out_lim_r;

  `ASSERT_CLK(a_limit_level, !(out_valid_r && out_lim_r) || (out_level_r == '0) || (out_level_r == genv_pkg::LEVEL_MAX), "at_limit set away from an end level")
  `ASSERT_NEXT(a_adv_result, s1_adv, out_valid_r, "advanced request produced no result")
  `ASSERT_NEXT(a_direct_hold, s1_adv && !s1_restart_r && !gain_r[7], $stable(tick_cnt_r) && $stable(level_r), "direct-mode tick changed state")
  `ASSERT_NEXT(a_stall_keep, in_stall, s1_valid_r, "held request dropped while stalled")

endmodule

// ===== tb/envelope_checker.sv =====
`timescale 1ns / 1ps

module envelope_checker
  import genv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [GAIN_W-1:0]         cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_restart,
  input  logic signed [START_W-1:0] in_start_level,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [LEVEL_W-1:0]        out_level,
  input  logic                      out_at_limit,
  output int                        fail_count,
  output int                        pending,
  output int                        results_checked
);

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               at_limit;
  } level_result_t;

  // Ticks between steps, indexed by the rate field; rate 0 never counts.
  localparam logic [15:0] TICK_PERIOD [32] = '{
    16'h7800, 16'd2048, 16'd1536, 16'd1280, 16'd1024, 16'd768, 16'd640, 16'd512,
    16'd384,  16'd320,  16'd256,  16'd192,  16'd160,  16'd128, 16'd96,  16'd80,
    16'd64,   16'd48,   16'd40,   16'd32,   16'd24,   16'd20,  16'd16,  16'd12,
    16'd10,   16'd8,    16'd6,    16'd5,    16'd4,    16'd3,   16'd2,   16'd1
  };

  logic [GAIN_W-1:0]  gain_copy;
  logic [LEVEL_W-1:0] env_level;
  logic [CNT_W-1:0]   tick_count;
  level_result_t      expected_levels [$];
  level_result_t      want;

  function automatic logic [LEVEL_W-1:0] stepped_level(input logic [2:0] mode,
                                                       input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] dec;
    logic [LEVEL_W:0]   sum;
    dec = lv - 1'b1;
    sum = {1'b0, lv} + ((mode == MODE_BENT_UP && lv > BEND_POINT) ? BENT_STEP : LINEAR_STEP);
    case (mode)
      MODE_LIN_DOWN: return (lv > LINEAR_STEP) ? lv - LINEAR_STEP : '0;
      MODE_EXP_DOWN: return (lv == '0) ? '0 : dec - (dec >> 8);
      default:       return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_W-1:0];
    endcase
  endfunction

  // Advances the envelope for one request and returns the level it should show.
  function automatic level_result_t predict_level(input logic restart,
                                                  input logic signed [START_W-1:0] start);
    logic [2:0]     mode;
    logic [4:0]     rate;
    logic [CNT_W:0] count_next;
    logic           at_end;
    level_result_t  r;
    mode   = gain_copy[7:5];
    rate   = gain_copy[4:0];
    at_end = (mode < MODE_LIN_UP) ? (env_level == '0) : (env_level == LEVEL_MAX);
    if (restart) begin
      if (start < 0)
        env_level = '0;
      else if (start > 16'sd2047)
        env_level = LEVEL_MAX;
      else
        env_level = start[LEVEL_W-1:0];
      tick_count = '0;
    end else if (mode >= MODE_LIN_DOWN && rate != 5'd0) begin
      count_next = {1'b0, tick_count} + 1'b1;
      // a count already past the period (rate lowered mid-count) also fires
      if (count_next >= TICK_PERIOD[rate]) begin
        count_next = '0;
        if (!at_end)
          env_level = stepped_level(mode, env_level);
      end
      tick_count = count_next[CNT_W-1:0];
    end
    if (mode < MODE_LIN_DOWN) begin
      r.level    = {gain_copy[6:0], 4'b0000};
      r.at_limit = 1'b0;
    end else begin
      r.level    = env_level;
      r.at_limit = (mode < MODE_LIN_UP) ? (env_level == '0) : (env_level == LEVEL_MAX);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_copy  = '0;
      env_level  = '0;
      tick_count = '0;
      expected_levels.delete();
      pending    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request pending: level %h at_limit %b",
                     $time, out_level, out_at_limit);
        end else begin
          want = expected_levels.pop_front();
          results_checked++;
          if (out_level !== want.level || out_at_limit !== want.at_limit) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: level exp %h got %h, at_limit exp %b got %b", $time,
                       want.level, out_level, want.at_limit, out_at_limit);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_levels.insert(expected_levels.size(),
                               predict_level(in_restart, in_start_level));
      if (cfg_wr_en)
        gain_copy = cfg_wr_data;
      pending = expected_levels.size();
    end
  end

endmodule

// ===== tb/gain_envelope_stepper_tb.sv =====
`timescale 1ns / 1ps

module gain_envelope_stepper_tb;
  import genv_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_REQUESTS = 1150;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      cfg_wr_en      = 1'b0;
  logic [GAIN_W-1:0]         cfg_wr_data    = '0;
  logic                      in_valid       = 1'b0;
  logic                      in_restart     = 1'b0;
  logic signed [START_W-1:0] in_start_level = '0;
  logic                      out_stall      = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic [LEVEL_W-1:0]        out_level;
  logic                      out_at_limit;

  int fail_count;
  int pending;
  int results_checked;
  int cycle_count   = 0;
  int requests_sent = 0;
  int restarts_sent = 0;
  int gain_writes   = 0;
  bit no_idle       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gain_envelope_stepper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .in_start_level (in_start_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_at_limit   (out_at_limit)
  );

  envelope_checker level_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .in_start_level  (in_start_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_at_limit    (out_at_limit),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [2:0] mode;
    logic [4:0] rate;
    mode = 3'($urandom_range(4, 7));
    rate = 5'($urandom_range(16, 31));
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1: begin
        mode = 3'($urandom_range(0, 3));
        rate = 5'($urandom);
      end
      2: rate = 5'd0;
      3: rate = 5'($urandom_range(1, 15));
      default: ;
    endcase
    return {mode, rate};
  endfunction

  function automatic logic signed [START_W-1:0] pick_start();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 11))
          0:  return 16'h0000;
          1:  return 16'h0001;
          2:  return 16'h07ff;
          3:  return 16'h0800;
          4:  return 16'h7fff;
          5:  return 16'h8000;
          6:  return 16'hffff;
          7:  return 16'h05ff;
          8:  return 16'h0600;
          9:  return 16'h0601;
          10: return 16'h07e0;
          default: return 16'h0021;
        endcase
      end
      6: return 16'($urandom_range(1536, 2047));
      7: return 16'($urandom_range(0, 64));
      default: return 16'($urandom_range(0, 2047));
    endcase
  endfunction

  // Gain is only changed with nothing in flight.
  task automatic write_gain(input logic [GAIN_W-1:0] g);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = g;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    gain_writes++;
  endtask

  // Entered and left at a falling edge; valid stays high across back-to-back requests.
  task automatic send_req(input logic r, input logic signed [START_W-1:0] v);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid       = 1'b0;
      in_restart     = 1'($urandom);
      in_start_level = 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_restart     = r;
    in_start_level = v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    requests_sent++;
    if (r)
      restarts_sent++;
  endtask

  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int   random_sent;
    int   n;
    logic r;
    random_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // direct levels at both ends of the gain byte
    write_gain(8'h00);
    send_req(1'b1, 16'h7fff);
    send_req(1'b0, 16'h0000);
    write_gain(8'h7f);
    send_req(1'b1, 16'h8000);
    send_req(1'b0, 16'hffff);
    // frozen rate
    write_gain(8'he0);
    send_req(1'b1, 16'h05ff);
    send_req(1'b0, 16'h0000);
    // bent up at the fastest rate: across the bend, into the clamp, then held
    write_gain(8'hff);
    send_req(1'b1, 16'h0600);
    send_req(1'b0, 16'h0000);
    send_req(1'b0, 16'h0000);
    send_req(1'b1, 16'h07f8);
    send_req(1'b0, 16'h0000);
    send_req(1'b0, 16'h0000);
    // linear down to the floor
    write_gain(8'h9f);
    send_req(1'b1, 16'h0021);
    send_req(1'b0, 16'h0000);
    send_req(1'b0, 16'h0000);
    send_req(1'b0, 16'h0000);
    // exponential down
    write_gain(8'hbf);
    send_req(1'b1, 16'h07ff);
    send_req(1'b0, 16'h0000);
    send_req(1'b1, 16'h0001);
    send_req(1'b0, 16'h0000);
    send_req(1'b0, 16'h0000);
    // linear up, start above range and below zero
    write_gain(8'hdf);
    send_req(1'b1, 16'h0800);
    send_req(1'b0, 16'h0000);
    send_req(1'b1, 16'hffff);

    // Tick counter carries over gain changes, so rate switches land mid-count.
    while (random_sent < RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      write_gain(pick_gain());
      n = $urandom_range(8, 60);
      for (int i = 0; i < n; i++) begin
        r = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
        send_req(r, pick_start());
      end
      random_sent += n;
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("Sent %0d requests (%0d restarts) over %0d gain settings; %0d results checked.",
             requests_sent, restarts_sent, gain_writes, results_checked);
    $display("Direct, frozen, slow and fast rates in all envelope modes, random idle gaps.");
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
